// ===== hw/rtl/ata_tf_pkg.sv =====
// Shared constants, codes and the Identify image function for the ATA task-file device.
// No dependencies.
package ata_tf_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int BUF_AW       = $clog2(SECTOR_BYTES);

    // transaction commands
    localparam logic [2:0] CMD_REG_RD   = 3'd0;
    localparam logic [2:0] CMD_REG_WR   = 3'd1;
    localparam logic [2:0] CMD_FILL     = 3'd2;
    localparam logic [2:0] CMD_FETCH    = 3'd3;
    localparam logic [2:0] CMD_RD_DONE  = 3'd4;
    localparam logic [2:0] CMD_WR_DONE  = 3'd5;

    // task registers
    localparam logic [3:0] REG_DATA   = 4'd0;
    localparam logic [3:0] REG_ERR    = 4'd1;
    localparam logic [3:0] REG_COUNT  = 4'd2;
    localparam logic [3:0] REG_SECTOR = 4'd3;
    localparam logic [3:0] REG_CYL_LO = 4'd4;
    localparam logic [3:0] REG_CYL_HI = 4'd5;
    localparam logic [3:0] REG_HEAD   = 4'd6;
    localparam logic [3:0] REG_STATUS = 4'd7;
    localparam logic [3:0] REG_DEVCTL = 4'd14;

    // ATA command bytes
    localparam logic [7:0] ATA_READ     = 8'h20;
    localparam logic [7:0] ATA_WRITE    = 8'h30;
    localparam logic [7:0] ATA_IDENTIFY = 8'hEC;
    localparam logic [7:0] ATA_SETFEAT  = 8'hEF;

    localparam logic [7:0] ST_BSY  = 8'h80;
    localparam logic [7:0] ST_DRDY = 8'h40;
    localparam logic [7:0] ST_DSC  = 8'h10;
    localparam logic [7:0] ST_DRQ  = 8'h08;

    localparam logic [2:0] MODE_CHS   = 3'd5;
    localparam logic [2:0] MODE_LBA28 = 3'd7;
    localparam logic [2:0] MODE_LBA48 = 3'd2;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [2:0] FLT_OK        = 3'd0;
    localparam logic [2:0] FLT_RD_IDLE   = 3'd1;
    localparam logic [2:0] FLT_WR_IDLE   = 3'd2;
    localparam logic [2:0] FLT_BAD_REG   = 3'd3;
    localparam logic [2:0] FLT_BAD_CMD   = 3'd4;
    localparam logic [2:0] FLT_LBA48     = 3'd5;
    localparam logic [2:0] FLT_NO_8BIT   = 3'd6;
    localparam logic [2:0] FLT_CHS_SEC0  = 3'd7;

    localparam logic [1:0] CFG_DISK  = 2'd0;
    localparam logic [1:0] CFG_TOTAL = 2'd1;
    localparam logic [1:0] CFG_CYL   = 2'd2;

    // Identify image, one byte per buffer position
    function automatic logic [7:0] ident_byte(input logic [BUF_AW-1:0] idx,
                                              input logic [9:0] cyl,
                                              input logic [27:0] tot);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            9'd2:    b = cyl[7:0];
            9'd3:    b = {6'b0, cyl[9:8]};
            9'd6:    b = 8'd16;
            9'd12:   b = 8'd63;
            9'd120:  b = tot[7:0];
            9'd121:  b = tot[15:8];
            9'd122:  b = tot[23:16];
            9'd123:  b = {4'b0, tot[27:24]};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/ata_tf_in_if.sv =====
// Host/disk event channel of the ATA task-file device.
// Depends on ata_tf_pkg.
interface ata_tf_in_if import ata_tf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [3:0]        reg_addr;
    logic [7:0]        write_data;
    logic [BUF_AW-1:0] byte_index;

    modport source (output valid, command, reg_addr, write_data, byte_index, input ready);
    modport sink   (input valid, command, reg_addr, write_data, byte_index, output ready);
endinterface

// ===== hw/rtl/ata_tf_out_if.sv =====
// Result channel of the ATA task-file device.
// No dependencies.
interface ata_tf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [1:0]  disk_request;
    logic [27:0] sector_address;
    logic [2:0]  fault;

    modport source (output valid, read_data, disk_request, sector_address, fault,
                    input ready);
    modport sink   (input valid, read_data, disk_request, sector_address, fault,
                    output ready);
endinterface

// ===== hw/rtl/ata_tf_buf.sv =====
// 512 x 8 sector buffer, one write and one registered read port.
// Depends on ata_tf_pkg.
module ata_tf_buf import ata_tf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [BUF_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [BUF_AW-1:0] i_raddr,
    output logic [7:0]        o_rdata
);
    logic [7:0] r_mem [SECTOR_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ata_task_file_device.sv =====
// ATA task-file device: one transaction is accepted, the sector buffer is read in that
// cycle, and the next state decodes it and loads the result register, waiting there
// while the result register is still held; no new transaction is taken until then. Identify
// rewrites the whole buffer afterwards, one byte a cycle, holding off input until it is done.
// Depends on ata_tf_pkg, ata_tf_in_if, ata_tf_out_if, ata_tf_buf.
module ata_task_file_device import ata_tf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [27:0] i_cfg_data,
    ata_tf_in_if.sink   i_in,
    ata_tf_out_if.source o_out
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_CLR  = 2'd2;

    logic [1:0]        r_state;
    logic              r_disk;
    logic [27:0]       r_total;
    logic [9:0]        r_cyl;
    logic [2:0]        r_cmd;
    logic [3:0]        r_ra;
    logic [7:0]        r_wd;
    logic [BUF_AW-1:0] r_bi;
    logic [BUF_AW:0]   r_ptr;
    logic [8:0]        r_left;
    logic              r_rd_act, r_wr_act, r_bmode, r_feat;
    logic [7:0]        r_status, r_error;
    logic [7:0]        r_count, r_sec, r_cyl_lo, r_cyl_hi, r_last;
    logic [3:0]        r_head;
    logic              r_slave;
    logic [2:0]        r_mode;
    logic [BUF_AW-1:0] r_clr;

    logic              r_ov;
    logic [7:0]        r_ord;
    logic [1:0]        r_oreq;
    logic [27:0]       r_oaddr;
    logic [2:0]        r_oflt;

    logic [7:0]        mem_rdata;
    logic              mem_we;
    logic [BUF_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    logic              accept, fire;
    logic [7:0]        n_rd;
    logic [1:0]        n_req;
    logic [27:0]       n_addr;
    logic [2:0]        n_flt;
    logic [27:0]       sec_addr;
    logic              sec_flt;
    logic [19:0]       chs_cyl;
    logic [27:0]       chs_addr;
    logic              mode_ok;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign fire = (r_state == S_EXEC) && (!r_ov || o_out.ready);
    assign mode_ok = (r_mode == MODE_CHS) || (r_mode == MODE_LBA28);

    ata_tf_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (r_state == S_IDLE),
        .i_raddr ((i_in.command == CMD_FETCH) ? i_in.byte_index : r_ptr[BUF_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // CHS: ((cyl*16 + head)*63 + sector - 1), *63 as *64 - x
    assign chs_cyl  = {r_cyl_hi, r_cyl_lo, r_head};
    assign chs_addr = {2'b0, chs_cyl, 6'b0} - {8'b0, chs_cyl} + {20'b0, r_sec} - 28'd1;

    always_comb begin
        sec_addr = 28'd0;
        sec_flt  = 1'b0;
        if (r_mode == MODE_CHS) begin
            sec_addr = chs_addr;
            sec_flt  = (r_sec == 8'd0);
        end else if (r_mode == MODE_LBA28) begin
            sec_addr = {r_head, r_cyl_hi, r_cyl_lo, r_sec};
        end
    end

    // result and buffer write of the transaction in decode, or the Identify image write while clearing
    always_comb begin
        n_rd = 8'h00;
        n_req = REQ_NONE;
        n_addr = 28'd0;
        n_flt = FLT_OK;
        mem_we = 1'b0;
        mem_waddr = r_bi;
        mem_wdata = r_wd;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = ident_byte(r_clr, r_cyl, r_total);
        end else if (fire) begin
            case (r_cmd)
                CMD_REG_RD: begin
                    if (!r_disk) begin
                        n_rd = 8'hFF;
                    end else begin
                        case (r_ra)
                            REG_DATA: begin
                                if (!r_rd_act || r_ptr[BUF_AW]) begin
                                    n_flt = FLT_RD_IDLE;
                                end else begin
                                    n_rd = mem_rdata;
                                end
                            end
                            REG_ERR:    n_rd = r_error;
                            REG_COUNT:  n_rd = r_count;
                            REG_SECTOR: n_rd = r_sec;
                            REG_CYL_LO: n_rd = r_cyl_lo;
                            REG_CYL_HI: n_rd = r_cyl_hi;
                            REG_HEAD:   n_rd = {r_mode, r_slave, r_head};
                            REG_STATUS, REG_DEVCTL: n_rd = r_status;
                            default:    n_flt = FLT_BAD_REG;
                        endcase
                    end
                end
                CMD_REG_WR: begin
                    if (r_disk) begin
                        case (r_ra)
                            REG_DATA: begin
                                if (!r_wr_act || r_ptr[BUF_AW]) begin
                                    n_flt = FLT_WR_IDLE;
                                end else begin
                                    mem_we = 1'b1;
                                    mem_waddr = r_ptr[BUF_AW-1:0];
                                    if (&r_ptr[BUF_AW-1:0]) begin
                                        n_req = REQ_WRITE;
                                        n_addr = sec_addr;
                                        if (sec_flt) n_flt = FLT_CHS_SEC0;
                                    end
                                end
                            end
                            REG_ERR, REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI,
                            REG_HEAD, REG_DEVCTL: ;
                            REG_STATUS: begin
                                case (r_wd)
                                    ATA_READ: begin
                                        if (!r_bmode) begin
                                            n_flt = FLT_NO_8BIT;
                                        end else if (mode_ok) begin
                                            n_req = REQ_READ;
                                            n_addr = sec_addr;
                                            if (sec_flt) n_flt = FLT_CHS_SEC0;
                                        end else if (r_mode == MODE_LBA48) begin
                                            n_flt = FLT_LBA48;
                                        end
                                    end
                                    ATA_WRITE: begin
                                        if (!r_bmode) n_flt = FLT_NO_8BIT;
                                        else if (!mode_ok && r_mode == MODE_LBA48)
                                            n_flt = FLT_LBA48;
                                    end
                                    ATA_IDENTIFY: if (!r_bmode) n_flt = FLT_NO_8BIT;
                                    ATA_SETFEAT: ;
                                    default: n_flt = FLT_BAD_CMD;
                                endcase
                            end
                            default: n_flt = FLT_BAD_REG;
                        endcase
                    end
                end
                CMD_FILL:  mem_we = 1'b1;
                CMD_FETCH: n_rd = mem_rdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_disk <= 1'b0;
            r_total <= 28'd0;
            r_cyl <= 10'd0;
            r_ptr <= '0;
            r_left <= 9'd0;
            r_rd_act <= 1'b0;
            r_wr_act <= 1'b0;
            r_bmode <= 1'b0;
            r_feat <= 1'b0;
            r_status <= 8'hFF;
            r_error <= 8'hFF;
            r_count <= 8'd0;
            r_sec <= 8'd0;
            r_cyl_lo <= 8'd0;
            r_cyl_hi <= 8'd0;
            r_last <= 8'd0;
            r_head <= 4'd0;
            r_slave <= 1'b0;
            r_mode <= 3'd0;
            r_clr <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DISK: begin
                        r_disk <= i_cfg_data[0];
                        r_status <= i_cfg_data[0] ? (ST_DRDY | ST_DSC) : 8'hFF;
                        r_error <= i_cfg_data[0] ? 8'h01 : 8'hFF;
                    end
                    CFG_TOTAL: r_total <= i_cfg_data;
                    CFG_CYL:   r_cyl <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (o_out.ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) r_state <= S_EXEC;
                S_CLR: begin
                    r_clr <= r_clr + BUF_AW'(1);
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_EXEC: if (fire) begin
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                    case (r_cmd)
                        CMD_REG_RD: if (r_disk && r_ra == REG_DATA && r_rd_act
                                        && !r_ptr[BUF_AW]) begin
                            if (&r_ptr[BUF_AW-1:0]) begin
                                r_ptr <= '0;
                                if (r_left <= 9'd1) begin
                                    r_left <= 9'd0;
                                    r_rd_act <= 1'b0;
                                    r_status <= (r_status & ~(ST_DRQ | ST_BSY)) | ST_DRDY;
                                end else begin
                                    r_left <= r_left - 9'd1;
                                end
                            end else begin
                                r_ptr <= r_ptr + (BUF_AW+1)'(1);
                            end
                        end
                        CMD_REG_WR: if (r_disk) begin
                            case (r_ra)
                                REG_DATA: if (r_wr_act && !r_ptr[BUF_AW]) begin
                                    r_ptr <= r_ptr + (BUF_AW+1)'(1);
                                    if (&r_ptr[BUF_AW-1:0]) r_status <= r_status | ST_BSY;
                                end
                                REG_ERR:    r_feat <= r_wd[0];
                                REG_COUNT:  r_count <= r_wd;
                                REG_SECTOR: r_sec <= r_wd;
                                REG_CYL_LO: r_cyl_lo <= r_wd;
                                REG_CYL_HI: r_cyl_hi <= r_wd;
                                REG_HEAD: begin
                                    r_head <= r_wd[3:0];
                                    r_slave <= r_wd[4];
                                    r_mode <= r_wd[7:5];
                                end
                                REG_STATUS: begin
                                    r_last <= r_wd;
                                    case (r_wd)
                                        ATA_READ: begin
                                            r_status <= r_status | ST_BSY;
                                            if (r_bmode && mode_ok)
                                                r_left <= (r_count == 8'd0) ? 9'd256
                                                                            : {1'b0, r_count};
                                        end
                                        ATA_WRITE: if (r_bmode && mode_ok) begin
                                            r_status <= r_status | ST_DRQ;
                                            r_wr_act <= 1'b1;
                                            r_ptr <= '0;
                                        end
                                        ATA_IDENTIFY: if (r_bmode) begin
                                            r_rd_act <= 1'b1;
                                            r_wr_act <= 1'b0;
                                            r_ptr <= '0;
                                            r_left <= 9'd1;
                                            r_status <= (r_status & ~ST_BSY) | ST_DRDY
                                                        | ST_DSC | ST_DRQ;
                                            r_clr <= '0;
                                            r_state <= S_CLR;
                                        end
                                        ATA_SETFEAT: r_bmode <= r_feat;
                                        default: ;
                                    endcase
                                end
                                REG_DEVCTL: begin
                                    r_rd_act <= 1'b0;
                                    r_wr_act <= 1'b0;
                                    r_status <= ST_DRDY | ST_DSC;
                                    r_error <= 8'h01;
                                end
                                default: ;
                            endcase
                        end
                        CMD_RD_DONE: begin
                            r_status <= (r_status & ~ST_BSY) | ST_DRQ;
                            r_ptr <= '0;
                            r_rd_act <= 1'b1;
                        end
                        CMD_WR_DONE: begin
                            r_status <= r_status & ~(ST_BSY | ST_DRQ);
                            r_wr_act <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in.command;
            r_ra <= i_in.reg_addr;
            r_wd <= i_in.write_data;
            r_bi <= i_in.byte_index;
        end
        if (fire) begin
            r_ord <= n_rd;
            r_oreq <= n_req;
            r_oaddr <= n_addr;
            r_oflt <= n_flt;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.read_data = r_ord;
    assign o_out.disk_request = r_oreq;
    assign o_out.sector_address = r_oaddr;
    assign o_out.fault = r_oflt;

    // last command byte is kept for the task file but has no read path
    logic unused_last;
    assign unused_last = ^r_last;
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the ATA task-file device: register, buffer and completion traffic.
// Depends on ata_tf_pkg, ata_tf_in_if, ata_tf_out_if and the device RTL.
module tb_top import ata_tf_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [1:0]  req;
        logic [27:0] addr;
        logic [2:0]  flt;
    } t_ata_result;

    // device state mirror and expected results
    class t_ata_scoreboard;
        bit         disk;
        bit [27:0]  total;
        bit [9:0]   cyl;
        bit [7:0]   buffer [SECTOR_BYTES];
        bit [9:0]   ptr;
        bit [8:0]   left;
        bit         rd_act, wr_act, byte_on, feat_bit;
        bit [7:0]   status, error;
        bit [7:0]   tregs [5];
        bit [3:0]   head;
        bit         slave;
        bit [2:0]   mode;
        bit         ctl;
        t_ata_result pending [$];
        int         errors;

        task report_mismatch(string what, longint got, longint exp);
            errors++;
            $display("mismatch %0s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        endtask

        function void load_status();
            if (disk) begin
                status = ST_DRDY | ST_DSC;
                error = 8'h01;
            end else begin
                status = 8'hFF;
                error = 8'hFF;
            end
        endfunction

        function void set_cfg(bit [1:0] idx, bit [27:0] v);
            case (idx)
                CFG_DISK: begin
                    disk = v[0];
                    load_status();
                end
                CFG_TOTAL: total = v;
                CFG_CYL: cyl = v[9:0];
                default: ;
            endcase
        endfunction

        function bit [27:0] lba_of(inout bit [2:0] f);
            bit [31:0] s, cl, ch, hd;
            s = tregs[1]; cl = tregs[2]; ch = tregs[3]; hd = head;
            if (mode == MODE_CHS) begin
                if (s == 0) f = FLT_CHS_SEC0;
                return 28'(((((ch << 8) + cl) * 16 + hd) * 63) + s - 1);
            end
            if (mode == MODE_LBA28) return 28'((hd << 24) | (ch << 16) | (cl << 8) | s);
            return 28'd0;
        endfunction

        function void run_cmd(bit [7:0] v, inout t_ata_result r);
            tregs[4] = v;
            case (v)
                ATA_READ: begin
                    status |= ST_BSY;
                    if (!byte_on) r.flt = FLT_NO_8BIT;
                    else if (mode == MODE_CHS || mode == MODE_LBA28) begin
                        left = (tregs[0] != 0) ? tregs[0] : 9'd256;
                        r.req = REQ_READ;
                        r.addr = lba_of(r.flt);
                    end else if (mode == MODE_LBA48) r.flt = FLT_LBA48;
                end
                ATA_WRITE: begin
                    if (!byte_on) r.flt = FLT_NO_8BIT;
                    else if (mode == MODE_CHS || mode == MODE_LBA28) begin
                        status |= ST_DRQ;
                        wr_act = 1;
                        ptr = 0;
                    end else if (mode == MODE_LBA48) r.flt = FLT_LBA48;
                end
                ATA_IDENTIFY: begin
                    if (!byte_on) r.flt = FLT_NO_8BIT;
                    else begin
                        foreach (buffer[i]) buffer[i] = 0;
                        buffer[2] = cyl[7:0];
                        buffer[3] = {6'b0, cyl[9:8]};
                        buffer[6] = 8'd16;
                        buffer[12] = 8'd63;
                        buffer[120] = total[7:0];
                        buffer[121] = total[15:8];
                        buffer[122] = total[23:16];
                        buffer[123] = {4'b0, total[27:24]};
                        rd_act = 1; wr_act = 0; ptr = 0; left = 1;
                        status = (status & ~ST_BSY) | ST_DRDY | ST_DSC | ST_DRQ;
                    end
                end
                ATA_SETFEAT: byte_on = feat_bit;
                default: r.flt = FLT_BAD_CMD;
            endcase
        endfunction

        function void note_input(bit [2:0] cmd, bit [3:0] ra, bit [7:0] wd, bit [8:0] bi);
            t_ata_result r;
            r = '0;
            case (cmd)
                CMD_REG_RD: begin
                    if (!disk) r.rdata = 8'hFF;
                    else case (ra)
                        REG_DATA: begin
                            if (!rd_act || ptr >= SECTOR_BYTES) r.flt = FLT_RD_IDLE;
                            else begin
                                r.rdata = buffer[ptr[8:0]];
                                ptr++;
                                if (ptr >= SECTOR_BYTES) begin
                                    ptr = 0;
                                    if (left <= 1) begin
                                        left = 0;
                                        rd_act = 0;
                                        status = (status & ~(ST_DRQ | ST_BSY)) | ST_DRDY;
                                    end else left--;
                                end
                            end
                        end
                        REG_ERR: r.rdata = error;
                        REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI: r.rdata = tregs[ra - 2];
                        REG_HEAD: r.rdata = {mode, slave, head};
                        REG_STATUS, REG_DEVCTL: r.rdata = status;
                        default: r.flt = FLT_BAD_REG;
                    endcase
                end
                CMD_REG_WR: if (disk) case (ra)
                    REG_DATA: begin
                        if (!wr_act || ptr >= SECTOR_BYTES) r.flt = FLT_WR_IDLE;
                        else begin
                            buffer[ptr[8:0]] = wd;
                            ptr++;
                            if (ptr >= SECTOR_BYTES) begin
                                status |= ST_BSY;
                                r.req = REQ_WRITE;
                                r.addr = lba_of(r.flt);
                            end
                        end
                    end
                    REG_ERR: feat_bit = wd[0];
                    REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI: tregs[ra - 2] = wd;
                    REG_HEAD: begin
                        head = wd[3:0];
                        slave = wd[4];
                        mode = wd[7:5];
                    end
                    REG_STATUS: run_cmd(wd, r);
                    REG_DEVCTL: begin
                        ctl = wd[1];
                        rd_act = 0;
                        wr_act = 0;
                        load_status();
                    end
                    default: r.flt = FLT_BAD_REG;
                endcase
                CMD_FILL: buffer[bi] = wd;
                CMD_FETCH: r.rdata = buffer[bi];
                CMD_RD_DONE: begin
                    status = (status & ~ST_BSY) | ST_DRQ;
                    ptr = 0;
                    rd_act = 1;
                end
                CMD_WR_DONE: begin
                    status = status & ~(ST_BSY | ST_DRQ);
                    wr_act = 0;
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        task check_result(t_ata_result got);
            t_ata_result exp;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", 0, 0);
                return;
            end
            exp = pending.pop_front();
            if (got.rdata !== exp.rdata) report_mismatch("read_data", got.rdata, exp.rdata);
            if (got.req !== exp.req) report_mismatch("disk_request", got.req, exp.req);
            if (got.addr !== exp.addr) report_mismatch("sector_address", got.addr, exp.addr);
            if (got.flt !== exp.flt) report_mismatch("fault", got.flt, exp.flt);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [27:0] i_cfg_data;
    ata_tf_in_if  in_ch ();
    ata_tf_out_if out_ch ();

    t_ata_scoreboard sb;
    bit  steady;         // no idling on either side
    bit  drain;
    longint cycles;
    bit  written [SECTOR_BYTES];

    ata_task_file_device u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2_000_000) begin
                $display("timeout");
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side: random stall, check on handshake
    initial begin
        out_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result({out_ch.read_data, out_ch.disk_request,
                                 out_ch.sector_address, out_ch.fault});
            out_ch.ready <= steady || drain || ($urandom_range(99) >= 37);
        end
    end

    // valid stays up after acceptance; the next send or an idle cycle drops it
    task automatic send(bit [2:0] cmd, bit [3:0] ra, bit [7:0] wd, bit [8:0] bi);
        bit       data_wr;
        bit [8:0] data_at;
        while (!steady && $urandom_range(99) < 37) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.command <= cmd;
        in_ch.reg_addr <= ra;
        in_ch.write_data <= wd;
        in_ch.byte_index <= bi;
        do @(posedge i_clk); while (!in_ch.ready);
        data_wr = (cmd == CMD_REG_WR && ra == REG_DATA && sb.disk && sb.wr_act
                   && sb.ptr < SECTOR_BYTES);
        data_at = sb.ptr[8:0];
        sb.note_input(cmd, ra, wd, bi);
        if (cmd == CMD_FILL) written[bi] = 1;
        if (cmd == CMD_REG_WR && ra == REG_STATUS && wd == ATA_IDENTIFY && sb.disk
            && sb.byte_on) foreach (written[i]) written[i] = 1;
        if (data_wr) written[data_at] = 1;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_cfg(bit [1:0] idx, bit [27:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_cfg(idx, v);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic reg_wr(bit [3:0] ra, bit [7:0] v);
        send(CMD_REG_WR, ra, v, 9'($urandom));
    endtask

    // random item; data reads and fetches only when the byte was written
    task automatic random_item();
        bit [2:0] cmd;
        bit [3:0] ra;
        bit [8:0] bi;
        int k;
        k = $urandom_range(99);
        ra = 4'($urandom);
        bi = 9'($urandom);
        if (k < 30) cmd = CMD_REG_RD;
        else if (k < 65) cmd = CMD_REG_WR;
        else if (k < 80) cmd = CMD_FILL;
        else if (k < 88) cmd = CMD_FETCH;
        else if (k < 92) cmd = CMD_RD_DONE;
        else if (k < 96) cmd = CMD_WR_DONE;
        else cmd = 3'($urandom_range(7, 6));
        if (cmd == CMD_REG_RD && ra == REG_DATA && sb.disk && sb.rd_act
            && !written[sb.ptr[8:0]]) ra = REG_STATUS;
        if (cmd == CMD_REG_WR && ra == REG_STATUS && $urandom_range(1))
            case ($urandom_range(3))
                0: ra = REG_DEVCTL;
                default: ;
            endcase
        if (cmd == CMD_FETCH && !written[bi]) cmd = CMD_FILL;
        if (cmd == CMD_RD_DONE && !written[0]) cmd = CMD_WR_DONE;
        send(cmd, ra, 8'($urandom), bi);
    endtask

    // setup then a write, read or Identify command over a full or partial sector, random content
    task automatic sector_seq();
        bit [7:0] md;
        md = ($urandom_range(3) != 0) ? ($urandom_range(1) ? 8'hE0 : 8'hA0)
                                      : 8'($urandom);
        reg_wr(REG_ERR, 8'h01);
        reg_wr(REG_STATUS, ATA_SETFEAT);
        reg_wr(REG_HEAD, md | 8'($urandom_range(31)));
        reg_wr(REG_SECTOR, 8'($urandom));
        reg_wr(REG_CYL_LO, 8'($urandom));
        reg_wr(REG_CYL_HI, 8'($urandom));
        reg_wr(REG_COUNT, 8'($urandom_range(3)));
        case ($urandom_range(2))
            0: begin
                reg_wr(REG_STATUS, ATA_WRITE);
                repeat ($urandom_range(1) ? 512 : 40) reg_wr(REG_DATA, 8'($urandom));
                send(CMD_WR_DONE, 0, 0, 0);
            end
            1: begin
                reg_wr(REG_STATUS, ATA_READ);
                for (int i = 0; i < 512; i++)
                    if (!written[i]) send(CMD_FILL, 0, 8'($urandom), 9'(i));
                send(CMD_RD_DONE, 0, 0, 0);
                repeat ($urandom_range(1) ? 512 : 30) send(CMD_REG_RD, REG_DATA, 0, 0);
            end
            default: begin
                reg_wr(REG_STATUS, ATA_IDENTIFY);
                repeat (130) send(CMD_REG_RD, REG_DATA, 0, 0);
            end
        endcase
    endtask

    initial begin
        sb = new();
        sb.load_status();
        steady = 0;
        drain = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_DISK;
        i_cfg_data = 0;
        in_ch.valid = 0;
        in_ch.command = CMD_REG_RD;
        in_ch.reg_addr = REG_DATA;
        in_ch.write_data = 0;
        in_ch.byte_index = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // no disk: register writes ignored, register reads give all ones
        send(CMD_REG_WR, REG_COUNT, 8'hFF, 9'h1FF);
        send(CMD_REG_RD, REG_COUNT, 0, 0);
        send(CMD_FILL, 0, 8'hA5, 9'd511);
        send(CMD_FETCH, 0, 0, 9'd511);
        send(3'd6, 4'hF, 8'hFF, 9'h1FF);
        send(3'd7, 0, 0, 0);
        wait_idle();

        write_cfg(CFG_DISK, 1);
        write_cfg(CFG_TOTAL, 28'hFFFFFFF);
        write_cfg(CFG_CYL, 10'h3FF);
        send(CMD_REG_RD, REG_DATA, 0, 0);              // data read idle
        reg_wr(REG_DATA, 8'h55);                       // data write idle
        send(CMD_REG_RD, 4'd9, 0, 0);                  // bad register
        reg_wr(4'd15, 8'h00);
        reg_wr(REG_STATUS, ATA_READ);                  // 8-bit not enabled
        reg_wr(REG_STATUS, 8'h91);                     // unknown command
        reg_wr(REG_ERR, 8'h01);
        reg_wr(REG_STATUS, ATA_SETFEAT);
        reg_wr(REG_HEAD, 8'h4F);                       // lba48
        reg_wr(REG_STATUS, ATA_READ);
        reg_wr(REG_STATUS, ATA_WRITE);
        reg_wr(REG_HEAD, 8'hBF);                       // chs, sector zero
        reg_wr(REG_SECTOR, 8'h00);
        reg_wr(REG_CYL_LO, 8'hFF);
        reg_wr(REG_CYL_HI, 8'hFF);
        reg_wr(REG_STATUS, ATA_READ);
        send(CMD_REG_RD, REG_HEAD, 0, 0);
        send(CMD_REG_RD, REG_ERR, 0, 0);
        reg_wr(REG_DEVCTL, 8'h02);
        send(CMD_REG_RD, REG_DEVCTL, 0, 0);
        reg_wr(REG_STATUS, ATA_IDENTIFY);
        repeat (125) send(CMD_REG_RD, REG_DATA, 0, 0);
        wait_idle();

        write_cfg(CFG_TOTAL, 0);
        write_cfg(CFG_CYL, 0);
        steady = 1;
        repeat (2) sector_seq();
        steady = 0;
        for (int ph = 0; ph < 4; ph++) begin
            repeat (60) random_item();
            wait_idle();
            write_cfg(CFG_DISK, (ph != 2));
            write_cfg(CFG_TOTAL, 28'($urandom));
            write_cfg(CFG_CYL, 10'($urandom));
        end

        drain = 1;
        wait_idle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== ata_task_file_device.f =====
hw/rtl/ata_tf_pkg.sv
hw/rtl/ata_tf_in_if.sv
hw/rtl/ata_tf_out_if.sv
hw/rtl/ata_tf_buf.sv
hw/rtl/ata_task_file_device.sv
dv/tb_top.sv
